// ----- rtl/simon64_128_decrypt_core_defines.svh -----
// assertion macros shared by the simon decrypt core modules
`ifndef SIMON64_128_DECRYPT_CORE_DEFINES_SVH
`define SIMON64_128_DECRYPT_CORE_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define SIMON_DEC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define SIMON_DEC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/simon_dec_pkg.sv -----
// shared types, constants and helpers for the simon 64/128 decrypt core
`default_nettype none

package simon_dec_pkg;

   localparam int WORD_W    = 32;
   localparam int ROUNDS    = 44;
   localparam int KEY_WORDS = 4;
   localparam int KEY_IDX_W = $clog2(ROUNDS);
   localparam int KEY_SEL_W = $clog2(KEY_WORDS);
   localparam int CSR_IDX_W = 3;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam key_idx_type LAST_ROUND = KEY_IDX_W'(ROUNDS - 1);

   // register indexes of the configuration port
   localparam csr_idx_type CSR_KEY_WORD0 = CSR_IDX_W'(0);
   localparam csr_idx_type CSR_KEY_WORD1 = CSR_IDX_W'(1);
   localparam csr_idx_type CSR_KEY_WORD2 = CSR_IDX_W'(2);
   localparam csr_idx_type CSR_KEY_WORD3 = CSR_IDX_W'(3);

   // z3 sequence, leftmost bit is element 0
   localparam logic [0:61] Z3_SEQ =
      62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11;

   localparam word_type KEY_CONST = WORD_W'(3);

   // input word: ciphertext pair
   typedef struct packed {
      word_type cipher_first;
      word_type cipher_second;
   } req_word_type;

   // output word: plaintext pair
   typedef struct packed {
      word_type plain_first;
      word_type plain_second;
   } rsp_word_type;

   // configuration write as seen by the key expander
   typedef struct packed {
      logic        en;
      csr_idx_type index;
      word_type    data;
   } csr_wr_type;

   // round key store write port
   typedef struct packed {
      logic        en;
      key_idx_type addr;
      word_type    data;
   } key_wr_type;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic word_type rotr(input word_type v, input int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/simon64_128_decrypt_core.sv -----
// Simon 64/128 decryption core. A word on req_data carries two 32-bit
// ciphertext words; rsp_data returns the two plaintext words after 44 rounds.
// One round unit is reused once per cycle, reading one round key per cycle
// from a 44-entry key store except while the last round holds; a word
// finishes all of its rounds before the core will accept the next word.
// The result sits in an output register, so a new word is taken while the
// previous result waits; the last round holds until that register frees up.
// The four key words are written through the csr port at indexes 0 to 3
// (other indexes are ignored). After reset and after every key write the
// round keys are regenerated into the store, one per cycle, and req_stall
// stays high during that time.
`default_nettype none

module simon64_128_decrypt_core
   import simon_dec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire csr_idx_type  csr_index,
   input  wire word_type     csr_data
);

   csr_wr_type  csr_wr;
   key_wr_type  key_wr;
   logic        key_busy;
   key_idx_type key_addr;
   word_type    key_data;

   // configuration writes are always taken
   assign csr_ready    = 1'b1;
   assign csr_wr.en    = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // key expansion
   simon_dec_keyexp u_keyexp (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .key_wr   (key_wr),
      .key_busy (key_busy)
   );

   // round key store
   simon_dec_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROUNDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr.en),
      .wr_addr (key_wr.addr),
      .wr_data (key_wr.data),
      .rd_addr (key_addr),
      .rd_data (key_data)
   );

   // round engine
   simon_dec_round u_round (
      .clock     (clock),
      .reset     (reset),
      .key_busy  (key_busy),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .key_addr  (key_addr),
      .key_data  (key_data)
   );

endmodule

`default_nettype wire

// ----- rtl/simon_dec_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module simon_dec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 44,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/simon_dec_keyexp.sv -----
// key registers and round key expansion, one key per cycle into the key store
`default_nettype none
`include "simon64_128_decrypt_core_defines.svh"

module simon_dec_keyexp
   import simon_dec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire csr_wr_type csr_wr,
   output key_wr_type      key_wr,
   output logic            key_busy
);

   word_type    key_ff [KEY_WORDS];
   word_type    key_in [KEY_WORDS];
   word_type    win_ff [KEY_WORDS];
   key_idx_type idx_ff;
   logic        busy_ff;
   logic        key_hit;
   word_type    t0;
   word_type    t1;
   word_type    new_key;
   logic        z_bit;

   // register decode
   always_comb begin
      for (int i = 0; i < KEY_WORDS; i++) begin
         key_in[i] = key_ff[i];
      end
      key_hit = 1'b0;
      if (csr_wr.en) begin
         unique case (csr_wr.index)
            CSR_KEY_WORD0: begin key_in[0] = csr_wr.data; key_hit = 1'b1; end
            CSR_KEY_WORD1: begin key_in[1] = csr_wr.data; key_hit = 1'b1; end
            CSR_KEY_WORD2: begin key_in[2] = csr_wr.data; key_hit = 1'b1; end
            CSR_KEY_WORD3: begin key_in[3] = csr_wr.data; key_hit = 1'b1; end
            default: key_hit = 1'b0;
         endcase
      end
   end

   // one expansion step over the window of the last four keys
   assign z_bit = Z3_SEQ[idx_ff - KEY_IDX_W'(KEY_WORDS)];
   assign t0    = rotr(win_ff[3], 3) ^ win_ff[1];
   assign t1    = t0 ^ rotr(t0, 1);

   always_comb begin
      if (idx_ff < KEY_IDX_W'(KEY_WORDS)) begin
         new_key = key_ff[idx_ff[KEY_SEL_W-1:0]];
      end else begin
         new_key = ~win_ff[0] ^ t1 ^ {{(WORD_W-1){1'b0}}, z_bit} ^ KEY_CONST;
      end
   end

   // key registers and expansion sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= key_in[i];
         end
         if (key_hit) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (idx_ff == LAST_ROUND) begin
               busy_ff <= 1'b0;
               idx_ff  <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // key window shift
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         for (int i = 0; i < KEY_WORDS - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[KEY_WORDS-1] <= new_key;
      end
   end

   assign key_wr.en   = busy_ff;
   assign key_wr.addr = idx_ff;
   assign key_wr.data = new_key;
   assign key_busy    = busy_ff;

   `SIMON_DEC_ASSERT_NEXT(a_key_write_restarts, key_hit, busy_ff && idx_ff == '0)
   `SIMON_DEC_ASSERT_IMPL(a_idle_index_clear, !busy_ff, idx_ff == '0)

endmodule

`default_nettype wire

// ----- rtl/simon_dec_round.sv -----
// decrypt round sequencer, shared round unit and result register
`default_nettype none
`include "simon64_128_decrypt_core_defines.svh"

module simon_dec_round
   import simon_dec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         key_busy,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   output key_idx_type       key_addr,
   input  wire word_type     key_data
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type    state_ff, state_in;
   key_idx_type  round_ff, round_in;
   word_type     a_ff, a_in;
   word_type     b_ff, b_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   word_type     step;
   logic         accept;
   logic         out_free;
   logic         round_done;

   assign req_stall = (state_ff != ST_IDLE) || key_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // last round finishing into a free result register
   assign round_done = (state_ff == ST_RUN) && (round_ff == LAST_ROUND) && out_free;

   // shared round function
   assign step = a_ff ^ (rotl(b_ff, 1) & rotl(b_ff, 8)) ^ rotl(b_ff, 2) ^ key_data;

   // key fetch one round ahead, held on the last round while stalled
   always_comb begin
      if (state_ff == ST_IDLE) begin
         key_addr = LAST_ROUND;
      end else if (round_ff == LAST_ROUND) begin
         key_addr = '0;
      end else begin
         key_addr = LAST_ROUND - KEY_IDX_W'(1) - round_ff;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in     = req_data.cipher_first;
               b_in     = req_data.cipher_second;
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (round_ff != LAST_ROUND) begin
               a_in     = b_ff;
               b_in     = step;
               round_in = round_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.plain_first  = b_ff;
               rsp_data_in.plain_second = step;
               round_in                 = '0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SIMON_DEC_ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_RUN && round_ff == '0)
   `SIMON_DEC_ASSERT_IMPL(a_idle_round_clear, state_ff == ST_IDLE, round_ff == '0)
   `SIMON_DEC_ASSERT_NEXT(a_finish_loads_rsp, round_done, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire
